FILE: rtl/rsz_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear resize package
// Shared item types, register indexes and arithmetic constants for the
// bilinear resize and normalize sampler.
// ----------------------------------------------------------------------------
package rsz_pkg;

    // Input item: a store of one source byte or a sample request.
    typedef struct packed {
        logic        mode;
        logic [17:0] store_address;
        logic [7:0]  store_value;
        logic [7:0]  out_x;
        logic [7:0]  out_y;
        logic [1:0]  out_channel;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic signed [15:0] norm_value;
        logic               ok;
    } t_out_item;

    // Item modes.
    localparam logic MODE_STORE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_CHANNELS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_IS_RGB   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT   = 3'd5;
    localparam int CFG_DATA_W = 9;

    // Coordinate divider: 25-bit dividend, 9-bit divisor, 5 bits per stage.
    localparam int DIV_DW     = 25;
    localparam int DIV_VW     = 9;
    localparam int DIV_STEP   = 5;
    localparam int DIV_STAGES = DIV_DW / DIV_STEP;

    typedef struct packed {
        logic [DIV_VW-1:0] rem;
        logic [DIV_DW-1:0] dvd;
        logic [DIV_DW-1:0] quo;
        logic [DIV_VW-1:0] dvs;
    } t_div_st;

    // Normalization: q = floor(t / 255) as (t * NORM_K) >> NORM_SHIFT,
    // exact for t below 2^22.
    localparam logic [22:0]        NORM_K     = 23'd4210753;
    localparam int                 NORM_SHIFT = 30;
    localparam logic signed [26:0] NORM_OFS   = 27'sd16711680;
    localparam logic [25:0]        NORM_HALF  = 26'd510;
    localparam int                 NORM_LAT   = 4;

endpackage

FILE: rtl/rsz_div.sv
// ----------------------------------------------------------------------------
// Coordinate divider
// Pipelined restoring divider, a fixed number of quotient bits per stage.
// ----------------------------------------------------------------------------
module rsz_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [rsz_pkg::DIV_DW-1:0]   i_dividend,
    input  logic [rsz_pkg::DIV_VW-1:0]   i_divisor,
    output logic [rsz_pkg::DIV_DW-1:0]   o_quot
);

    // A group of restoring steps, one quotient bit each.
    function automatic rsz_pkg::t_div_st div_steps(input rsz_pkg::t_div_st s);
        rsz_pkg::t_div_st        o;
        logic [rsz_pkg::DIV_VW:0] w;
        logic [rsz_pkg::DIV_VW:0] d;
        o = s;
        for (int k = 0; k < rsz_pkg::DIV_STEP; k++) begin
            w     = {o.rem, o.dvd[rsz_pkg::DIV_DW-1]};
            o.dvd = {o.dvd[rsz_pkg::DIV_DW-2:0], 1'b0};
            d     = w - {1'b0, o.dvs};
            if (w >= {1'b0, o.dvs}) begin
                o.rem = d[rsz_pkg::DIV_VW-1:0];
                o.quo = {o.quo[rsz_pkg::DIV_DW-2:0], 1'b1};
            end else begin
                o.rem = w[rsz_pkg::DIV_VW-1:0];
                o.quo = {o.quo[rsz_pkg::DIV_DW-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    rsz_pkg::t_div_st r_st [rsz_pkg::DIV_STAGES];
    rsz_pkg::t_div_st n_st [rsz_pkg::DIV_STAGES];
    rsz_pkg::t_div_st w_init;

    // Stage inputs: the first stage starts from a zero remainder.
    always_comb begin
        w_init.rem = '0;
        w_init.dvd = i_dividend;
        w_init.quo = '0;
        w_init.dvs = i_divisor;
        n_st[0]    = div_steps(w_init);
        for (int s = 1; s < rsz_pkg::DIV_STAGES; s++) begin
            n_st[s] = div_steps(r_st[s-1]);
        end
    end

    // Stage registers advance with the pipeline.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_quot = r_st[rsz_pkg::DIV_STAGES-1].quo;

endmodule

FILE: rtl/rsz_frame.sv
// ----------------------------------------------------------------------------
// Frame memory
// Source byte store, held in two copies with two read ports each so that a
// full 2x2 neighborhood is read at once.
// ----------------------------------------------------------------------------
module rsz_frame #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [7:0]           i_wr_data,
    input  logic [3:0][AW-1:0]   i_rd_addr,
    output logic [3:0][7:0]      o_rd_data
);

    logic [7:0]      r_mem_a [DEPTH];
    logic [7:0]      r_mem_b [DEPTH];
    logic [3:0][7:0] r_rd_data;

    // Writes go to both copies; each copy serves two of the four reads.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_wr_en) begin
                r_mem_a[i_wr_addr] <= i_wr_data;
                r_mem_b[i_wr_addr] <= i_wr_data;
            end
            r_rd_data[0] <= r_mem_a[i_rd_addr[0]];
            r_rd_data[1] <= r_mem_a[i_rd_addr[1]];
            r_rd_data[2] <= r_mem_b[i_rd_addr[2]];
            r_rd_data[3] <= r_mem_b[i_rd_addr[3]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/rsz_norm.sv
// ----------------------------------------------------------------------------
// Blend and normalize
// Bilinear blend of a 2x2 neighborhood and conversion to Q1.14 magnitude
// and sign, four register stages.
// ----------------------------------------------------------------------------
module rsz_norm (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [3:0][7:0] i_pix,
    input  logic [7:0]      i_wx,
    input  logic [7:0]      i_wy,
    output logic [15:0]     o_q,
    output logic            o_neg
);

    logic [16:0] r_top;
    logic [16:0] r_bot;
    logic [7:0]  r_wy;
    logic [24:0] r_v;
    logic [21:0] r_t;
    logic        r_neg1;
    logic [15:0] r_q;
    logic        r_neg2;

    logic [8:0]         w_wxn;
    logic [8:0]         w_wyn;
    logic signed [26:0] w_n;
    logic [26:0]        w_mag;
    logic [25:0]        w_m;
    logic [44:0]        w_prod;

    // Weights, signed offset, rounding magnitude and reciprocal product.
    always_comb begin
        w_wxn  = 9'd256 - {1'b0, i_wx};
        w_wyn  = 9'd256 - {1'b0, r_wy};
        w_n    = $signed({1'b0, r_v, 1'b0}) - rsz_pkg::NORM_OFS;
        w_mag  = w_n[26] ? 27'(-w_n) : 27'(w_n);
        w_m    = w_mag[25:0] + rsz_pkg::NORM_HALF;
        w_prod = {22'd0, r_t} * {22'd0, rsz_pkg::NORM_K};
    end

    // Horizontal blend, vertical blend, rounding, divide by 255.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_top  <= 17'({9'd0, i_pix[0]} * {8'd0, w_wxn}) +
                      17'({9'd0, i_pix[1]} * {9'd0, i_wx});
            r_bot  <= 17'({9'd0, i_pix[2]} * {8'd0, w_wxn}) +
                      17'({9'd0, i_pix[3]} * {9'd0, i_wx});
            r_wy   <= i_wy;
            r_v    <= 25'({8'd0, r_top} * {16'd0, w_wyn}) +
                      25'({8'd0, r_bot} * {17'd0, r_wy});
            r_t    <= w_m[23:2];
            r_neg1 <= w_n[26];
            r_q    <= w_prod[rsz_pkg::NORM_SHIFT +: 16];
            r_neg2 <= r_neg1;
        end
    end

    assign o_q   = r_q;
    assign o_neg = r_neg2;

endmodule

FILE: rtl/bilinear_resize_normalize.sv
// ----------------------------------------------------------------------------
// Bilinear resize and normalize sampler
// Maps an output element to half-pixel source coordinates, reads a 2x2
// neighborhood from the frame memory and returns the normalized blend.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle, stores and samples alike; the fixed-depth
// pipeline, the five-stage coordinate divider and the four-port frame
// memory all advance together and hold as a whole when the output stalls.
// Reset clears the pipeline valid bits and the source configuration, and sets
// the output size to 112x112; frame memory is undefined until written.
module bilinear_resize_normalize #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [rsz_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rsz_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rsz_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rsz_pkg::t_out_item                  o_out_data
);

    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int MEM_AW      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int CALC_AW     = (MEM_AW > 22) ? MEM_AW : 22;
    localparam logic [CALC_AW:0] DEPTH_V = (CALC_AW+1)'(FRAME_DEPTH);
    localparam logic [12:0] MAX_W_V = 13'(MAX_WIDTH);
    localparam logic [12:0] MAX_H_V = 13'(MAX_HEIGHT);
    localparam logic [2:0]  MAX_C_V = 3'(MAX_CHANNELS);
    localparam int DS = rsz_pkg::DIV_STAGES;

    // Per-item side data carried down to the memory stage.
    typedef struct packed {
        logic        mode;
        logic [17:0] st_addr;
        logic [7:0]  st_val;
        logic [1:0]  sch;
        logic        cbad;
    } t_side;

    // Configuration registers.
    logic [8:0] r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic [2:0] r_src_c;
    logic       r_rgb;

    // Pipeline registers.
    logic              r_v0;
    rsz_pkg::t_in_item r_it0;
    logic              r_v1;
    t_side             r_sd1;
    logic [17:0]       r_ax, r_ay;
    logic              r_dv  [DS];
    t_side             r_dsd [DS];
    logic              r_dzx [DS];
    logic              r_dzy [DS];
    logic              r_vc;
    t_side             r_sdc;
    logic [8:0]        r_x0, r_x1, r_y0, r_y1;
    logic [7:0]        r_wx_c, r_wy_c;
    logic              r_va;
    t_side             r_sda;
    logic [17:0]       r_row0, r_row1;
    logic [8:0]        r_x0a, r_x1a;
    logic [7:0]        r_wx_a, r_wy_a;
    logic              r_vb;
    t_side             r_sdb;
    logic [3:0][CALC_AW-1:0] r_addr;
    logic [3:0]        r_aok;
    logic [7:0]        r_wx_b, r_wy_b;
    logic              r_st_ok;
    logic [3:0]        r_rok;
    logic [7:0]        r_wx_m, r_wy_m;
    logic              r_nv [rsz_pkg::NORM_LAT+1];
    logic              r_out_valid;
    rsz_pkg::t_out_item r_out;

    logic                   w_adv;
    logic                   w_cfg_ok;
    t_side                  w_sd0;
    logic [1:0]             w_dch;
    logic                   w_zx, w_zy;
    logic [17:0]            w_dx, w_dy;
    logic [rsz_pkg::DIV_DW-1:0] w_qx_raw, w_qy_raw;
    logic [16:0]            w_limx, w_limy;
    logic [16:0]            w_qx, w_qy;
    logic [9:0]             w_x0p, w_y0p;
    logic [3:0][CALC_AW-1:0] w_addr;
    logic [3:0]             w_aok;
    logic [CALC_AW-1:0]     w_st_ext;
    logic [3:0][MEM_AW-1:0] w_rd_addr;
    logic [3:0][7:0]        w_rd_data;
    logic [3:0][7:0]        w_pix;
    logic [15:0]            w_q;
    logic                   w_neg;
    logic [8:0]             w_ch_row [4];
    logic [8:0]             w_ch_col [4];

    // The whole pipeline advances unless a finished result is held.
    assign w_adv      = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    // User holds configuration static while items are in flight; unenforced.
    assign w_cfg_ok = (r_src_w != 9'd0) && ({4'd0, r_src_w} <= MAX_W_V) &&
                      (r_src_h != 9'd0) && ({4'd0, r_src_h} <= MAX_H_V) &&
                      (r_src_c != 3'd0) && (r_src_c <= MAX_C_V) &&
                      (r_dst_w != 9'd0) && (r_dst_h != 9'd0);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= 9'd0;
            r_src_h <= 9'd0;
            r_src_c <= 3'd0;
            r_rgb   <= 1'b0;
            r_dst_w <= 9'd112;
            r_dst_h <= 9'd112;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rsz_pkg::CFG_SRC_WIDTH:    r_src_w <= i_cfg_wdata;
                rsz_pkg::CFG_SRC_HEIGHT:   r_src_h <= i_cfg_wdata;
                rsz_pkg::CFG_SRC_CHANNELS: r_src_c <= i_cfg_wdata[2:0];
                rsz_pkg::CFG_SRC_IS_RGB:   r_rgb   <= i_cfg_wdata[0];
                rsz_pkg::CFG_DST_WIDTH:    r_dst_w <= i_cfg_wdata;
                rsz_pkg::CFG_DST_HEIGHT:   r_dst_h <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Source channel choice; a channel outside the pixel reads as zero.
    always_comb begin
        w_dch         = r_it0.out_channel;
        w_sd0.mode    = r_it0.mode;
        w_sd0.st_addr = r_it0.store_address;
        w_sd0.st_val  = r_it0.store_value;
        w_sd0.cbad    = 1'b0;
        if (r_src_c == 3'd1) begin
            w_sd0.sch = 2'd0;
        end else if (r_rgb) begin
            w_sd0.sch  = 2'd2 - w_dch;
            w_sd0.cbad = (w_dch == 2'd3);
        end else begin
            w_sd0.sch = w_dch;
        end
        if ({1'b0, w_sd0.sch} >= r_src_c) begin
            w_sd0.cbad = 1'b1;
        end
    end

    // Divider operands: (a - d) * 128 over d, or zero when a <= d.
    always_comb begin
        w_zx = (r_ax <= {9'd0, r_dst_w});
        w_zy = (r_ay <= {9'd0, r_dst_h});
        w_dx = r_ax - {9'd0, r_dst_w};
        w_dy = r_ay - {9'd0, r_dst_h};
    end

    rsz_div u_div_x (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_dividend ({w_dx, 7'd0}),
        .i_divisor  (r_dst_w),
        .o_quot     (w_qx_raw)
    );

    rsz_div u_div_y (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_dividend ({w_dy, 7'd0}),
        .i_divisor  (r_dst_h),
        .o_quot     (w_qy_raw)
    );

    // Clamp to the last source pixel and split into index and weight.
    always_comb begin
        w_limx = {r_src_w - 9'd1, 8'd0};
        w_limy = {r_src_h - 9'd1, 8'd0};
        if (r_dzx[DS-1]) begin
            w_qx = 17'd0;
        end else if (w_qx_raw > {8'd0, w_limx}) begin
            w_qx = w_limx;
        end else begin
            w_qx = w_qx_raw[16:0];
        end
        if (r_dzy[DS-1]) begin
            w_qy = 17'd0;
        end else if (w_qy_raw > {8'd0, w_limy}) begin
            w_qy = w_limy;
        end else begin
            w_qy = w_qy_raw[16:0];
        end
        w_x0p = {1'b0, w_qx[16:8]} + 10'd1;
        w_y0p = {1'b0, w_qy[16:8]} + 10'd1;
    end

    // Interleaved addresses of the four neighbors.
    always_comb begin
        w_ch_row[0] = 9'd0;
        w_ch_row[1] = 9'd0;
        w_ch_row[2] = 9'd1;
        w_ch_row[3] = 9'd1;
        w_ch_col[0] = r_x0a;
        w_ch_col[1] = r_x1a;
        w_ch_col[2] = r_x0a;
        w_ch_col[3] = r_x1a;
        for (int k = 0; k < 4; k++) begin
            w_addr[k] = CALC_AW'(({1'b0, (w_ch_row[k][0] ? r_row1 : r_row0)} +
                                  {10'd0, w_ch_col[k]}) * {16'd0, r_src_c}) +
                        CALC_AW'(r_sda.sch);
            w_aok[k]  = ({1'b0, w_addr[k]} < DEPTH_V) && !r_sda.cbad;
        end
        w_st_ext = CALC_AW'(r_sdb.st_addr);
        for (int k = 0; k < 4; k++) begin
            w_rd_addr[k] = r_addr[k][MEM_AW-1:0];
        end
    end

    rsz_frame #(
        .DEPTH (FRAME_DEPTH),
        .AW    (MEM_AW)
    ) u_frame (
        .i_clk     (i_clk),
        .i_en      (w_adv),
        .i_wr_en   (r_vb && (r_sdb.mode == rsz_pkg::MODE_STORE) &&
                    ({1'b0, w_st_ext} < DEPTH_V)),
        .i_wr_addr (w_st_ext[MEM_AW-1:0]),
        .i_wr_data (r_sdb.st_val),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Out-of-range or invalid-channel reads give zero.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_pix[k] = r_rok[k] ? w_rd_data[k] : 8'd0;
        end
    end

    rsz_norm u_norm (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_pix (w_pix),
        .i_wx  (r_wx_m),
        .i_wy  (r_wy_m),
        .o_q   (w_q),
        .o_neg (w_neg)
    );

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_vc        <= 1'b0;
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < DS; s++) begin
                r_dv[s] <= 1'b0;
            end
            for (int s = 0; s <= rsz_pkg::NORM_LAT; s++) begin
                r_nv[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v0    <= i_in_valid;
            r_v1    <= r_v0;
            r_dv[0] <= r_v1;
            for (int s = 1; s < DS; s++) begin
                r_dv[s] <= r_dv[s-1];
            end
            r_vc    <= r_dv[DS-1];
            r_va    <= r_vc;
            r_vb    <= r_va;
            r_nv[0] <= r_vb && (r_sdb.mode == rsz_pkg::MODE_SAMPLE);
            for (int s = 1; s <= rsz_pkg::NORM_LAT; s++) begin
                r_nv[s] <= r_nv[s-1];
            end
            r_out_valid <= r_nv[rsz_pkg::NORM_LAT];
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // Capture, then source coordinate numerators (2o+1)*s.
            r_it0 <= i_in_data;
            r_sd1 <= w_sd0;
            r_ax  <= {1'b0, r_it0.out_x, 1'b1} * {9'd0, r_src_w};
            r_ay  <= {1'b0, r_it0.out_y, 1'b1} * {9'd0, r_src_h};
            // Side data running beside the dividers.
            r_dsd[0] <= r_sd1;
            r_dzx[0] <= w_zx;
            r_dzy[0] <= w_zy;
            for (int s = 1; s < DS; s++) begin
                r_dsd[s] <= r_dsd[s-1];
                r_dzx[s] <= r_dzx[s-1];
                r_dzy[s] <= r_dzy[s-1];
            end
            // Neighbor indexes and weights.
            r_sdc  <= r_dsd[DS-1];
            r_x0   <= w_qx[16:8];
            r_y0   <= w_qy[16:8];
            r_wx_c <= w_qx[7:0];
            r_wy_c <= w_qy[7:0];
            r_x1   <= (w_x0p < {1'b0, r_src_w}) ? w_x0p[8:0] : r_src_w - 9'd1;
            r_y1   <= (w_y0p < {1'b0, r_src_h}) ? w_y0p[8:0] : r_src_h - 9'd1;
            // Row offsets.
            r_sda  <= r_sdc;
            r_row0 <= {9'd0, r_y0} * {9'd0, r_src_w};
            r_row1 <= {9'd0, r_y1} * {9'd0, r_src_w};
            r_x0a  <= r_x0;
            r_x1a  <= r_x1;
            r_wx_a <= r_wx_c;
            r_wy_a <= r_wy_c;
            // Byte addresses.
            r_sdb  <= r_sda;
            r_addr <= w_addr;
            r_aok  <= w_aok;
            r_wx_b <= r_wx_a;
            r_wy_b <= r_wy_a;
            // Alongside the memory read.
            r_rok  <= r_aok;
            r_wx_m <= r_wx_b;
            r_wy_m <= r_wy_b;
            // Result register.
            r_out.ok         <= w_cfg_ok;
            r_out.norm_value <= !w_cfg_ok ? 16'sd0 :
                                w_neg ? $signed(16'(-w_q)) : $signed(w_q);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bilinear resize and normalize sampler testbench
// Loads small source images beat by beat and requests output samples
// under a series of register settings. Each sample is predicted from a
// private copy of the frame memory and registers, and every result beat is
// compared against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RUN_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 24;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    logic [rsz_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [rsz_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic                           i_in_valid;
    logic                           o_in_stall;
    rsz_pkg::t_in_item              i_in_data;
    logic                           o_out_valid;
    logic                           i_out_stall;
    rsz_pkg::t_out_item             o_out_data;

    bilinear_resize_normalize i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Shadow registers and frame memory of the predictor.
    logic [8:0]  sh_src_w, sh_src_h, sh_dst_w, sh_dst_h;
    logic [2:0]  sh_src_c;
    logic        sh_rgb;
    logic [7:0]  shadow_frame [int];

    rsz_pkg::t_in_item  pending_beats [$];
    rsz_pkg::t_out_item expected_samples [$];
    int          cycle_count;
    int          mismatch_count;
    int          sample_results;
    bit          calm;
    bit          pressure_done;
    int          hold_left;

    // Clock and cycle counter.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Quiet stretch: no idling on either side.
    always @(posedge i_clk) begin
        calm <= (cycle_count >= 1500 && cycle_count < 2500);
    end

    // Half-pixel source coordinate in Q8 for one axis.
    function automatic longint src_coord(longint o, longint s, longint d);
        longint a, q, lim;
        a = (2 * o + 1) * s;
        lim = (s - 1) * 256;
        if (a <= d) return 0;
        q = ((a - d) * 256) / (2 * d);
        return (q > lim) ? lim : q;
    endfunction

    function automatic longint frame_byte(longint x, longint y, longint ch);
        longint addr;
        if (ch < 0 || ch >= sh_src_c) return 0;
        addr = (y * sh_src_w + x) * sh_src_c + ch;
        return shadow_frame.exists(int'(addr)) ? shadow_frame[int'(addr)] : 0;
    endfunction

    // Predicted result of one sample request.
    function automatic rsz_pkg::t_out_item blend_sample(rsz_pkg::t_in_item it);
        rsz_pkg::t_out_item r;
        longint qx, qy, x0, y0, x1, y1, wx, wy, top, bot, v, n, k, ch;
        r = '0;
        if (sh_src_w == 0 || sh_src_w > 256 || sh_src_h == 0 || sh_src_h > 256 ||
            sh_src_c == 0 || sh_src_c > 4 || sh_dst_w == 0 || sh_dst_h == 0)
            return r;
        if (sh_src_c == 1) ch = 0;
        else if (sh_rgb) ch = 2 - longint'(it.out_channel);
        else ch = it.out_channel;
        qx = src_coord(it.out_x, sh_src_w, sh_dst_w);
        qy = src_coord(it.out_y, sh_src_h, sh_dst_h);
        x0 = qx >> 8; wx = qx & 255;
        y0 = qy >> 8; wy = qy & 255;
        x1 = (x0 + 1 < sh_src_w) ? x0 + 1 : sh_src_w - 1;
        y1 = (y0 + 1 < sh_src_h) ? y0 + 1 : sh_src_h - 1;
        top = frame_byte(x0, y0, ch) * (256 - wx) + frame_byte(x1, y0, ch) * wx;
        bot = frame_byte(x0, y1, ch) * (256 - wx) + frame_byte(x1, y1, ch) * wx;
        v = top * (256 - wy) + bot * wy;
        n = 2 * v - 16711680;
        if (n >= 0) k = (n + 510) / 1020;
        else k = -((-n + 510) / 1020);
        r.norm_value = k[15:0];
        r.ok = 1'b1;
        return r;
    endfunction

    task automatic push_store(int addr, int val);
        rsz_pkg::t_in_item it;
        it = '0;
        it.mode = rsz_pkg::MODE_STORE;
        it.store_address = addr[17:0];
        it.store_value = val[7:0];
        // Fill the unused sample fields with noise.
        it.out_x = $urandom_range(255);
        it.out_y = $urandom_range(255);
        it.out_channel = $urandom_range(3);
        shadow_frame[addr & 32'h3FFFF] = val[7:0];
        pending_beats.push_back(it);
    endtask

    task automatic push_sample(int x, int y, int ch);
        rsz_pkg::t_in_item it;
        it = '0;
        it.mode = rsz_pkg::MODE_SAMPLE;
        it.store_address = $urandom_range(262143);
        it.store_value = $urandom_range(255);
        it.out_x = x[7:0];
        it.out_y = y[7:0];
        it.out_channel = ch[1:0];
        expected_samples.push_back(blend_sample(it));
        pending_beats.push_back(it);
    endtask

    task automatic cfg_write(logic [rsz_pkg::CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val[rsz_pkg::CFG_DATA_W-1:0];
        case (idx)
            rsz_pkg::CFG_SRC_WIDTH:    sh_src_w = val[8:0];
            rsz_pkg::CFG_SRC_HEIGHT:   sh_src_h = val[8:0];
            rsz_pkg::CFG_SRC_CHANNELS: sh_src_c = val[2:0];
            rsz_pkg::CFG_SRC_IS_RGB:   sh_rgb = val[0];
            rsz_pkg::CFG_DST_WIDTH:    sh_dst_w = val[8:0];
            rsz_pkg::CFG_DST_HEIGHT:   sh_dst_h = val[8:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Block idle: all beats accepted, all results in, pipeline flushed.
    task automatic wait_idle();
        wait (pending_beats.size() == 0 && !i_in_valid && expected_samples.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_geometry(int w, int h, int c, int rgb, int dw, int dh);
        wait_idle();
        cfg_write(rsz_pkg::CFG_SRC_WIDTH, w);
        cfg_write(rsz_pkg::CFG_SRC_HEIGHT, h);
        cfg_write(rsz_pkg::CFG_SRC_CHANNELS, c);
        cfg_write(rsz_pkg::CFG_SRC_IS_RGB, rgb);
        cfg_write(rsz_pkg::CFG_DST_WIDTH, dw);
        cfg_write(rsz_pkg::CFG_DST_HEIGHT, dh);
    endtask

    // Write every byte of the source image so no sample reads stale memory.
    task automatic load_image();
        int total;
        if (sh_src_w == 0 || sh_src_w > 256 || sh_src_h == 0 || sh_src_h > 256 ||
            sh_src_c == 0 || sh_src_c > 4)
            return;
        total = sh_src_w * sh_src_h * sh_src_c;
        for (int a = 0; a < total; a++) push_store(a, $urandom_range(255));
    endtask

    // Mixed samples and stores under the current registers.
    task automatic sample_burst(int count);
        int total, x, y;
        bit valid_src;
        valid_src = !(sh_src_w == 0 || sh_src_w > 256 || sh_src_h == 0 ||
                      sh_src_h > 256 || sh_src_c == 0 || sh_src_c > 4);
        total = valid_src ? sh_src_w * sh_src_h * sh_src_c : 0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 25) begin
                if (total > 0 && $urandom_range(1))
                    push_store($urandom_range(total - 1), $urandom_range(255));
                else if (total < 262144)
                    push_store($urandom_range(262143 - total) + total, $urandom_range(255));
            end else begin
                if ($urandom_range(99) < 70 && sh_dst_w != 0 && sh_dst_h != 0) begin
                    x = $urandom_range((sh_dst_w > 256 ? 256 : sh_dst_w) - 1);
                    y = $urandom_range((sh_dst_h > 256 ? 256 : sh_dst_h) - 1);
                end else begin
                    x = $urandom_range(255);
                    y = $urandom_range(255);
                end
                push_sample(x, y, $urandom_range(3));
            end
        end
    endtask

    // Sender: offers queued beats when the slot is free, idling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_beats.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off, counted in cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!pressure_done && sample_results >= 150) begin
            pressure_done <= 1'b1;
            hold_left <= 300;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: random stall and result checking.
    always @(posedge i_clk) begin
        rsz_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                sample_results <= sample_results + 1;
                if (expected_samples.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected beat: norm=%0d ok=%0b",
                                 o_out_data.norm_value, o_out_data.ok);
                end else begin
                    want = expected_samples.pop_front();
                    if (o_out_data.norm_value !== want.norm_value ||
                        o_out_data.ok !== want.ok) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("mismatch: expected norm=%0d ok=%0b, got norm=%0d ok=%0b",
                                     want.norm_value, want.ok,
                                     o_out_data.norm_value, o_out_data.ok);
                    end
                end
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 27);
            end
        end
    end

    // Stimulus phases.
    initial begin
        int w, h, c, dw, dh, pick, random_beats;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        sample_results = 0;
        calm = 1'b0;
        pressure_done = 1'b0;
        hold_left = 0;
        sh_src_w = 0; sh_src_h = 0; sh_src_c = 0; sh_rgb = 0;
        sh_dst_w = 112; sh_dst_h = 112;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers at reset leave the source invalid.
        push_sample(0, 0, 0);
        push_sample(255, 255, 3);

        // Tiny RGB image with byte extremes; channel swap and unused channel.
        set_geometry(2, 2, 4, 1, 3, 3);
        for (int a = 0; a < 16; a++) push_store(a, (a % 2) ? 255 : 0);
        for (int ch = 0; ch < 4; ch++) push_sample(1, 1, ch);
        push_sample(0, 0, 0);
        push_sample(255, 255, 1);
        push_sample(2, 0, 2);

        // Single channel ignores the requested channel.
        set_geometry(1, 1, 1, 0, 1, 1);
        push_store(0, 255);
        push_sample(0, 0, 3);
        push_sample(200, 7, 2);

        // Widest and tallest sources, largest output.
        set_geometry(256, 1, 1, 0, 256, 256);
        load_image();
        push_sample(255, 0, 0);
        push_sample(0, 255, 1);
        set_geometry(1, 256, 1, 1, 1, 256);
        load_image();
        push_sample(0, 255, 0);
        push_sample(0, 128, 0);

        // Invalid size and channel settings; all bits set but the height.
        set_geometry(511, 4, 7, 1, 511, 511);
        push_sample(3, 3, 0);
        set_geometry(4, 4, 2, 0, 0, 4);
        push_sample(1, 1, 1);

        // Random register settings with well-formed image loads.
        random_beats = 0;
        while (random_beats < 700) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
            c = $urandom_range(1, 4);
            dw = ($urandom_range(1)) ? $urandom_range(1, 16) : $urandom_range(1, 256);
            dh = ($urandom_range(1)) ? $urandom_range(1, 16) : $urandom_range(1, 256);
            if ($urandom_range(99) < 8) begin
                pick = $urandom_range(6);
                case (pick)
                    0: w = 0;
                    1: w = $urandom_range(257, 511);
                    2: h = 0;
                    3: c = 0;
                    4: c = $urandom_range(5, 7);
                    5: dw = 0;
                    default: dh = 0;
                endcase
            end
            set_geometry(w, h, c, $urandom_range(1), dw, dh);
            pick = pending_beats.size();
            load_image();
            sample_burst(60);
            random_beats += pending_beats.size() - pick;
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
